>>> design/sil_pkg.sv
`timescale 1ns / 1ps

package sil_pkg;

   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // operation codes
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

   // operation broadcast to every cell
   typedef struct packed {
      logic                     insert_en;
      logic                     remove_en;
      logic signed [DATA_W-1:0] value;
   } cmd_type;

   // what a cell shows to its neighbors and to the top level
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     valid;
      logic                     ins_flag;
      logic                     eq;
      logic signed [DATA_W-1:0] next_value;
   } cell_type;

endpackage

>>> design/sil_cell.sv
`timescale 1ns / 1ps

module sil_cell (
   input  logic                clock,
   input  logic                reset,
   input  sil_pkg::cmd_type    cmd,
   input  sil_pkg::cell_type   left,
   input  sil_pkg::cell_type   right,
   output sil_pkg::cell_type   self
);

   logic signed [sil_pkg::DATA_W-1:0] value_ff, value_in;
   logic                              valid_ff, valid_in;
   logic                              gt, ge, eq;

   // compare the stored entry against the broadcast value
   assign gt = valid_ff && (value_ff >  cmd.value);
   assign ge = valid_ff && (value_ff >= cmd.value);
   assign eq = valid_ff && (value_ff == cmd.value);

   // insert: take the left entry if it moves too, else the new value
   // remove: pull the right entry in from every cell at or past the match
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (cmd.insert_en && (!valid_ff || gt)) begin
         value_in = left.ins_flag ? left.value : cmd.value;
         valid_in = left.ins_flag ? left.valid : 1'b1;
      end else if (cmd.remove_en && ge) begin
         value_in = right.value;
         valid_in = right.valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign self.value      = value_ff;
   assign self.valid      = valid_ff;
   assign self.ins_flag   = !valid_ff || gt;
   assign self.eq         = eq;
   assign self.next_value = value_in;

endmodule

>>> design/sorted_insertion_list.sv
`timescale 1ns / 1ps
// Sorted list of signed 32-bit values held in a row of compare-and-shift cells.
// The result beat is registered and appears in the cycle after the start beat.
// Throughput: one operation per cycle; all cells compare and shift together.
// busy stays low, so the receiver (which cannot stall) gets one beat per start.
// Reset (synchronous, active high) empties the list and drops any pending beat.

module sorted_insertion_list #(
   parameter int CAPACITY = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_action,
   input  logic signed [sil_pkg::DATA_W-1:0]   req_item_value,
   output logic                                rsp_strobe,
   output logic        [sil_pkg::STATUS_W-1:0] rsp_status,
   output logic        [sil_pkg::COUNT_W-1:0]  rsp_entry_count,
   output logic                                rsp_head_valid,
   output logic signed [sil_pkg::DATA_W-1:0]   rsp_head_value
);

   localparam int CLOG = $clog2(CAPACITY + 1);
   localparam int CW   = (CLOG > sil_pkg::COUNT_W) ? CLOG : sil_pkg::COUNT_W;

   sil_pkg::cmd_type               cmd;
   sil_pkg::cell_type              cells [CAPACITY];
   sil_pkg::cell_type              end_cell;
   logic [CAPACITY-1:0]            eq_vec;
   logic                           accept, full, found;
   logic [CW-1:0]                  cnt_ff, cnt_in;
   logic [sil_pkg::STATUS_W-1:0]   status;

   logic                                rsp_strobe_ff;
   logic        [sil_pkg::STATUS_W-1:0] rsp_status_ff;
   logic        [sil_pkg::COUNT_W-1:0]  rsp_count_ff;
   logic                                rsp_head_valid_ff;
   logic signed [sil_pkg::DATA_W-1:0]   rsp_head_value_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (cnt_ff == CW'(CAPACITY));
   assign found  = |eq_vec;

   // broadcast the operation; drop inserts when full, removes when absent
   assign cmd.insert_en = accept && (req_action == sil_pkg::ACT_INSERT) && !full;
   assign cmd.remove_en = accept && (req_action == sil_pkg::ACT_REMOVE) && found;
   assign cmd.value     = req_item_value;

   // empty neighbor past both ends of the row
   assign end_cell.value      = '0;
   assign end_cell.valid      = 1'b0;
   assign end_cell.ins_flag   = 1'b0;
   assign end_cell.eq         = 1'b0;
   assign end_cell.next_value = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      sil_pkg::cell_type left_nb, right_nb;
      if (i == 0) begin : g_first
         assign left_nb = end_cell;
      end else begin : g_mid_l
         assign left_nb = cells[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_nb = end_cell;
      end else begin : g_mid_r
         assign right_nb = cells[i+1];
      end
      sil_cell u_cell (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd),
         .left  (left_nb),
         .right (right_nb),
         .self  (cells[i])
      );
      assign eq_vec[i] = cells[i].eq;
   end

   // advance the count and pick the status
   always_comb begin
      cnt_in = cnt_ff;
      status = sil_pkg::ST_DONE;
      if (req_action == sil_pkg::ACT_INSERT) begin
         if (full) begin
            status = sil_pkg::ST_FULL;
         end else begin
            cnt_in = cnt_ff + CW'(1);
         end
      end else begin
         if (!found) begin
            status = sil_pkg::ST_NOT_FOUND;
         end else begin
            cnt_in = cnt_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
         if (accept) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   // register the result beat; its fields hold until the next accepted start
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff     <= status;
         rsp_count_ff      <= cnt_in[sil_pkg::COUNT_W-1:0];
         rsp_head_valid_ff <= (cnt_in != '0);
         rsp_head_value_ff <= (cnt_in != '0) ? cells[0].next_value : '0;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_head_valid  = rsp_head_valid_ff;
   assign rsp_head_value  = rsp_head_value_ff;

endmodule
